/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the date arithmetic block.
// Depends on nothing; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/gda_pkg.sv */
// Package of the Gregorian date arithmetic block: widths, control word types,
// calendar helper functions and the microprogram. Depends on nothing.
package gda_pkg;

	localparam int MAX_SPAN  = 65535;
	localparam int CNT_W     = $clog2(MAX_SPAN + 1);
	localparam int CNT_EXT_W = 23;
	localparam int YEAR_W    = 16;
	localparam int MON_W     = 4;
	localparam int DAY_W     = 5;
	localparam int AMT_W     = 16;
	localparam int FUNC_W    = 3;
	localparam int CNTO_W    = 16;
	localparam int ACC_W     = 17;
	localparam int K_W       = 13;
	localparam int PC_W      = 5;

	localparam logic [ACC_W-1:0]  DIV12_MAGIC  = 17'd87382;
	localparam int                DIV12_SHIFT  = 20;
	localparam logic [YEAR_W-1:0] INV25        = 16'd23593;
	localparam logic [YEAR_W-1:0] DIV25_LIMIT  = 16'd2621;
	localparam logic [MON_W-1:0]  MONTHS       = 4'd12;
	localparam logic [CNTO_W-1:0] CNT_OUT_MAX  = 16'hFFFF;

	typedef logic [PC_W-1:0] upc_t;

	typedef enum logic [FUNC_W-1:0] {
		F_LOAD       = 3'd0,
		F_ADD_DAYS   = 3'd1,
		F_ADD_MONTHS = 3'd2,
		F_ADD_YEARS  = 3'd3,
		F_DAYS_SINCE = 3'd4
	} func_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_IN_VALID,
		C_OUT_FREE,
		C_NOT_GT_LEN,
		C_LE12,
		C_WM_LT12,
		C_EQ,
		C_CNT_MAX
	} cond_t;

	typedef enum logic [2:0] {
		WY_HOLD, WY_STORED, WY_ARG, WY_ROLL, WY_ADD_K, WY_ADD_AMT
	} wy_sel_t;

	typedef enum logic [2:0] {
		WM_HOLD, WM_STORED, WM_ARG, WM_ADV, WM_ACC
	} wm_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD, ACC_DAY_AMT, ACC_MON_AMT, ACC_ARG_DAY,
		ACC_SUB_LEN, ACC_DEC, ACC_MOD12, ACC_INC
	} acc_sel_t;

	typedef enum logic [2:0] {
		ST_HOLD, ST_ARG, ST_WORK, ST_CLAMP, ST_YEAR
	} st_sel_t;

	typedef enum logic {
		CNT_HOLD, CNT_INC
	} cnt_op_t;

	typedef struct packed {
		logic     accept;
		logic     dispatch;
		logic     stay;
		cond_t    cond;
		upc_t     target;
		wy_sel_t  wy_sel;
		wm_sel_t  wm_sel;
		acc_sel_t acc_sel;
		st_sel_t  st_sel;
		cnt_op_t  cnt_op;
		logic     k_ld;
		logic     leap_ld;
		logic     ovf_en;
		logic     ovf_set;
		logic     out_ld;
	} ctl_t;

	localparam upc_t A_IDLE     = 5'd0;
	localparam upc_t A_LOAD     = 5'd1;
	localparam upc_t A_AD       = 5'd2;
	localparam upc_t A_AD_LEAP  = 5'd3;
	localparam upc_t A_AD_TEST  = 5'd4;
	localparam upc_t A_AD_ROLL  = 5'd5;
	localparam upc_t A_AD_YEAR  = 5'd6;
	localparam upc_t A_AD_WB    = 5'd7;
	localparam upc_t A_AM       = 5'd8;
	localparam upc_t A_AM_TEST  = 5'd9;
	localparam upc_t A_AM_DEC   = 5'd10;
	localparam upc_t A_AM_DIV   = 5'd11;
	localparam upc_t A_AM_MOD   = 5'd12;
	localparam upc_t A_AM_MON   = 5'd13;
	localparam upc_t A_AM_LEAP  = 5'd14;
	localparam upc_t A_AM_WB    = 5'd15;
	localparam upc_t A_AY       = 5'd16;
	localparam upc_t A_AY_ADD   = 5'd17;
	localparam upc_t A_AY_WB    = 5'd18;
	localparam upc_t A_DS       = 5'd19;
	localparam upc_t A_DS_LEAP  = 5'd20;
	localparam upc_t A_DS_EQ    = 5'd21;
	localparam upc_t A_DS_LIM_T = 5'd22;
	localparam upc_t A_DS_INC   = 5'd23;
	localparam upc_t A_DS_TEST  = 5'd24;
	localparam upc_t A_DS_ROLL  = 5'd25;
	localparam upc_t A_DS_YEAR  = 5'd26;
	localparam upc_t A_DS_LIMIT = 5'd27;
	localparam upc_t A_FIN      = 5'd28;
	localparam upc_t A_FIN_LEAP = 5'd29;
	localparam upc_t A_DONE     = 5'd30;

	localparam ctl_t CTL_NOP = '{
		accept:   1'b0,
		dispatch: 1'b0,
		stay:     1'b0,
		cond:     C_NONE,
		target:   A_IDLE,
		wy_sel:   WY_HOLD,
		wm_sel:   WM_HOLD,
		acc_sel:  ACC_HOLD,
		st_sel:   ST_HOLD,
		cnt_op:   CNT_HOLD,
		k_ld:     1'b0,
		leap_ld:  1'b0,
		ovf_en:   1'b0,
		ovf_set:  1'b0,
		out_ld:   1'b0
	};

	// Divisibility by 25 uses the modular inverse: y * inv(25) mod 2^16 is small
	// exactly when y is a multiple of 25.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [2*YEAR_W-1:0] prod;
		logic                div25;
		prod  = y * INV25;
		div25 = (prod[YEAR_W-1:0] <= DIV25_LIMIT);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
			input logic lp);
		logic [DAY_W-1:0] len;
		if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
			len = 5'd31;
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else if (m == 4'd2) begin
			len = lp ? 5'd29 : 5'd28;
		end else begin
			len = '0;
		end
		return len;
	endfunction

	function automatic upc_t entry(input logic [FUNC_W-1:0] f);
		upc_t a;
		case (func_t'(f))
			F_LOAD:       a = A_LOAD;
			F_ADD_DAYS:   a = A_AD;
			F_ADD_MONTHS: a = A_AM;
			F_ADD_YEARS:  a = A_AY;
			F_DAYS_SINCE: a = A_DS;
			default:      a = A_FIN;
		endcase
		return a;
	endfunction

	function automatic ctl_t ucode(input upc_t pc);
		ctl_t c;
		c = CTL_NOP;
		case (pc)
			A_IDLE: begin
				c.accept = 1'b1; c.dispatch = 1'b1; c.stay = 1'b1; c.cond = C_IN_VALID;
			end
			A_LOAD: begin
				c.st_sel = ST_ARG; c.cond = C_ALWAYS; c.target = A_FIN;
			end
			A_AD: begin
				c.wy_sel = WY_STORED; c.wm_sel = WM_STORED; c.acc_sel = ACC_DAY_AMT;
			end
			A_AD_LEAP: begin
				c.leap_ld = 1'b1;
			end
			A_AD_TEST: begin
				c.cond = C_NOT_GT_LEN; c.target = A_AD_WB;
			end
			A_AD_ROLL: begin
				c.acc_sel = ACC_SUB_LEN; c.wm_sel = WM_ADV; c.wy_sel = WY_ROLL;
				c.ovf_en = 1'b1; c.cond = C_WM_LT12; c.target = A_AD_TEST;
			end
			A_AD_YEAR: begin
				c.leap_ld = 1'b1; c.cond = C_ALWAYS; c.target = A_AD_TEST;
			end
			A_AD_WB: begin
				c.st_sel = ST_WORK; c.cond = C_ALWAYS; c.target = A_FIN;
			end
			A_AM: begin
				c.wy_sel = WY_STORED; c.acc_sel = ACC_MON_AMT;
			end
			A_AM_TEST: begin
				c.cond = C_LE12; c.target = A_AM_MON;
			end
			A_AM_DEC: begin
				c.acc_sel = ACC_DEC;
			end
			A_AM_DIV: begin
				c.k_ld = 1'b1;
			end
			A_AM_MOD: begin
				c.acc_sel = ACC_MOD12; c.wy_sel = WY_ADD_K; c.ovf_en = 1'b1;
			end
			A_AM_MON: begin
				c.wm_sel = WM_ACC;
			end
			A_AM_LEAP: begin
				c.leap_ld = 1'b1;
			end
			A_AM_WB: begin
				c.st_sel = ST_CLAMP; c.cond = C_ALWAYS; c.target = A_FIN;
			end
			A_AY: begin
				c.wy_sel = WY_STORED;
			end
			A_AY_ADD: begin
				c.wy_sel = WY_ADD_AMT; c.ovf_en = 1'b1;
			end
			A_AY_WB: begin
				c.st_sel = ST_YEAR; c.cond = C_ALWAYS; c.target = A_FIN;
			end
			A_DS: begin
				c.wy_sel = WY_ARG; c.wm_sel = WM_ARG; c.acc_sel = ACC_ARG_DAY;
			end
			A_DS_LEAP: begin
				c.leap_ld = 1'b1;
			end
			A_DS_EQ: begin
				c.cond = C_EQ; c.target = A_FIN;
			end
			A_DS_LIM_T: begin
				c.cond = C_CNT_MAX; c.target = A_DS_LIMIT;
			end
			A_DS_INC: begin
				c.acc_sel = ACC_INC; c.cnt_op = CNT_INC;
			end
			A_DS_TEST: begin
				c.cond = C_NOT_GT_LEN; c.target = A_DS_EQ;
			end
			A_DS_ROLL: begin
				c.acc_sel = ACC_SUB_LEN; c.wm_sel = WM_ADV; c.wy_sel = WY_ROLL;
				c.cond = C_WM_LT12; c.target = A_DS_TEST;
			end
			A_DS_YEAR: begin
				c.leap_ld = 1'b1; c.cond = C_ALWAYS; c.target = A_DS_TEST;
			end
			A_DS_LIMIT: begin
				c.ovf_set = 1'b1; c.cond = C_ALWAYS; c.target = A_FIN;
			end
			A_FIN: begin
				c.wy_sel = WY_STORED; c.wm_sel = WM_STORED;
			end
			A_FIN_LEAP: begin
				c.leap_ld = 1'b1;
			end
			A_DONE: begin
				c.out_ld = 1'b1; c.stay = 1'b1; c.cond = C_OUT_FREE; c.target = A_IDLE;
			end
			default: begin
				c.cond = C_ALWAYS; c.target = A_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

/* hdl/gregorian_date_arithmetic.sv */
// Top level of the Gregorian date arithmetic block: a microcoded sequencer
// over a small date datapath. Depends on gda_pkg and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    func, amount, arg_year, arg_month, arg_day
//   out      output     out_valid/out_ready  cur_year .. overflow
//
// Each item runs a short microprogram. Adding days rolls the month once per
// month crossed and reloads the leap flag once per year crossed; counting
// days steps forward one day at a time, rolling months as it goes, and is
// bounded by MAX_SPAN days.
// Reset restores the date 0-01-01. A result waiting on out_ready holds the
// sequencer in its last step; no new item is taken meanwhile.
`include "assert_macros.svh"

module gregorian_date_arithmetic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gda_pkg::FUNC_W-1:0]     func,
	input  logic [gda_pkg::AMT_W-1:0]      amount,
	input  logic [gda_pkg::YEAR_W-1:0]     arg_year,
	input  logic [gda_pkg::MON_W-1:0]      arg_month,
	input  logic [gda_pkg::DAY_W-1:0]      arg_day,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gda_pkg::YEAR_W-1:0]     cur_year,
	output logic [gda_pkg::MON_W-1:0]      cur_month,
	output logic [gda_pkg::DAY_W-1:0]      cur_day,
	output logic                           date_ok,
	output logic                           leap,
	output logic [gda_pkg::CNTO_W-1:0]     day_count,
	output logic                           overflow
);

	gda_pkg::upc_t                   pc_q, pc_d;
	gda_pkg::ctl_t                   cw;
	logic                            out_valid_q;
	logic [gda_pkg::YEAR_W-1:0]      year_q;
	logic [gda_pkg::MON_W-1:0]       month_q;
	logic [gda_pkg::DAY_W-1:0]       day_q;
	logic [gda_pkg::AMT_W-1:0]       amt_q;
	logic [gda_pkg::YEAR_W-1:0]      ay_q;
	logic [gda_pkg::MON_W-1:0]       am_q;
	logic [gda_pkg::DAY_W-1:0]       ad_q;
	logic [gda_pkg::YEAR_W-1:0]      wy_q, wy_d, wy_addend;
	logic [gda_pkg::YEAR_W:0]        wy_sum;
	logic [gda_pkg::MON_W-1:0]       wm_q, wm_d;
	logic [gda_pkg::ACC_W-1:0]       acc_q, acc_d, twelve_k;
	logic [2*gda_pkg::ACC_W-1:0]     div_prod;
	logic [gda_pkg::K_W-1:0]         k_q;
	logic                            leap_q;
	logic [gda_pkg::CNT_W-1:0]       cnt_q;
	logic                            ovf_q;
	logic [gda_pkg::DAY_W-1:0]       mlen;
	logic                            gt_len;
	logic                            cond_true;
	logic                            accept;
	logic                            out_busy;
	logic                            out_load;
	logic                            ok_d;
	logic [gda_pkg::CNT_EXT_W-1:0]   cnt_ext;
	logic                            cnt_sat;
	logic [gda_pkg::YEAR_W-1:0]      cur_year_q;
	logic [gda_pkg::MON_W-1:0]       cur_month_q;
	logic [gda_pkg::DAY_W-1:0]       cur_day_q;
	logic                            date_ok_q;
	logic                            leap_out_q;
	logic [gda_pkg::CNTO_W-1:0]      day_count_q;
	logic                            overflow_q;

	assign cw       = gda_pkg::ucode(pc_q);
	assign in_ready = cw.accept;
	assign accept   = in_valid && cw.accept;
	assign out_busy = out_valid_q && !out_ready;
	assign out_load = cw.out_ld && !out_busy;

	assign mlen   = gda_pkg::month_len(wm_q, leap_q);
	assign gt_len = acc_q > gda_pkg::ACC_W'(mlen);

	always_comb begin
		case (cw.cond)
			gda_pkg::C_ALWAYS:     cond_true = 1'b1;
			gda_pkg::C_IN_VALID:   cond_true = in_valid;
			gda_pkg::C_OUT_FREE:   cond_true = !out_busy;
			gda_pkg::C_NOT_GT_LEN: cond_true = !gt_len;
			gda_pkg::C_LE12:       cond_true = acc_q <= gda_pkg::ACC_W'(gda_pkg::MONTHS);
			gda_pkg::C_WM_LT12:    cond_true = wm_q < gda_pkg::MONTHS;
			gda_pkg::C_EQ:         cond_true = (wy_q == year_q) && (wm_q == month_q) &&
				(acc_q == gda_pkg::ACC_W'(day_q));
			gda_pkg::C_CNT_MAX:    cond_true = cnt_q >= gda_pkg::CNT_W'(gda_pkg::MAX_SPAN);
			default:               cond_true = 1'b0;
		endcase
	end

	always_comb begin
		if (cond_true) begin
			pc_d = cw.dispatch ? gda_pkg::entry(func) : cw.target;
		end else if (cw.stay) begin
			pc_d = pc_q;
		end else begin
			pc_d = pc_q + gda_pkg::PC_W'(1);
		end
	end

	always_comb begin
		case (cw.wy_sel)
			gda_pkg::WY_ROLL:    wy_addend = (wm_q >= gda_pkg::MONTHS) ?
				gda_pkg::YEAR_W'(1) : '0;
			gda_pkg::WY_ADD_K:   wy_addend = gda_pkg::YEAR_W'(k_q);
			gda_pkg::WY_ADD_AMT: wy_addend = amt_q;
			default:             wy_addend = '0;
		endcase
		wy_sum = {1'b0, wy_q} + {1'b0, wy_addend};
		case (cw.wy_sel)
			gda_pkg::WY_STORED: wy_d = year_q;
			gda_pkg::WY_ARG:    wy_d = ay_q;
			gda_pkg::WY_ROLL,
			gda_pkg::WY_ADD_K,
			gda_pkg::WY_ADD_AMT: wy_d = wy_sum[gda_pkg::YEAR_W-1:0];
			default:            wy_d = wy_q;
		endcase
	end

	always_comb begin
		case (cw.wm_sel)
			gda_pkg::WM_STORED: wm_d = month_q;
			gda_pkg::WM_ARG:    wm_d = am_q;
			gda_pkg::WM_ADV:    wm_d = (wm_q >= gda_pkg::MONTHS) ?
				gda_pkg::MON_W'(1) : wm_q + gda_pkg::MON_W'(1);
			gda_pkg::WM_ACC:    wm_d = acc_q[gda_pkg::MON_W-1:0];
			default:            wm_d = wm_q;
		endcase
	end

	always_comb begin
		twelve_k = gda_pkg::ACC_W'({k_q, 3'b000}) + gda_pkg::ACC_W'({k_q, 2'b00});
		case (cw.acc_sel)
			gda_pkg::ACC_DAY_AMT: acc_d = gda_pkg::ACC_W'(day_q) + gda_pkg::ACC_W'(amt_q);
			gda_pkg::ACC_MON_AMT: acc_d = gda_pkg::ACC_W'(month_q) + gda_pkg::ACC_W'(amt_q);
			gda_pkg::ACC_ARG_DAY: acc_d = gda_pkg::ACC_W'(ad_q);
			gda_pkg::ACC_SUB_LEN: acc_d = acc_q - gda_pkg::ACC_W'(mlen);
			gda_pkg::ACC_DEC:     acc_d = acc_q - gda_pkg::ACC_W'(1);
			gda_pkg::ACC_MOD12:   acc_d = acc_q - twelve_k + gda_pkg::ACC_W'(1);
			gda_pkg::ACC_INC:     acc_d = acc_q + gda_pkg::ACC_W'(1);
			default:              acc_d = acc_q;
		endcase
	end

	assign div_prod = acc_q * gda_pkg::DIV12_MAGIC;

	always_comb begin
		ok_d = (month_q >= gda_pkg::MON_W'(1)) && (month_q <= gda_pkg::MONTHS) &&
			(day_q != '0) && (day_q <= mlen);
		cnt_ext = gda_pkg::CNT_EXT_W'(cnt_q);
		cnt_sat = cnt_ext > gda_pkg::CNT_EXT_W'(gda_pkg::CNT_OUT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= gda_pkg::A_IDLE;
			out_valid_q <= 1'b0;
			year_q      <= '0;
			month_q     <= gda_pkg::MON_W'(1);
			day_q       <= gda_pkg::DAY_W'(1);
			cnt_q       <= '0;
		end else begin
			pc_q <= pc_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cw.st_sel)
				gda_pkg::ST_ARG: begin
					year_q  <= ay_q;
					month_q <= am_q;
					day_q   <= ad_q;
				end
				gda_pkg::ST_WORK: begin
					year_q  <= wy_q;
					month_q <= wm_q;
					day_q   <= acc_q[gda_pkg::DAY_W-1:0];
				end
				gda_pkg::ST_CLAMP: begin
					year_q  <= wy_q;
					month_q <= wm_q;
					day_q   <= (day_q > mlen) ? mlen : day_q;
				end
				gda_pkg::ST_YEAR: begin
					year_q <= wy_q;
				end
				default: begin
				end
			endcase
			if (accept) begin
				cnt_q <= '0;
			end else if (cw.cnt_op == gda_pkg::CNT_INC) begin
				cnt_q <= cnt_q + gda_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amt_q <= amount;
			ay_q  <= arg_year;
			am_q  <= arg_month;
			ad_q  <= arg_day;
			ovf_q <= 1'b0;
		end else if (cw.ovf_set || (cw.ovf_en && wy_sum[gda_pkg::YEAR_W])) begin
			ovf_q <= 1'b1;
		end
		wy_q  <= wy_d;
		wm_q  <= wm_d;
		acc_q <= acc_d;
		if (cw.k_ld) begin
			k_q <= div_prod[gda_pkg::DIV12_SHIFT +: gda_pkg::K_W];
		end
		if (cw.leap_ld) begin
			leap_q <= gda_pkg::is_leap(wy_q);
		end
		if (out_load) begin
			cur_year_q  <= year_q;
			cur_month_q <= month_q;
			cur_day_q   <= day_q;
			date_ok_q   <= ok_d;
			leap_out_q  <= leap_q;
			day_count_q <= cnt_sat ? gda_pkg::CNT_OUT_MAX : cnt_ext[gda_pkg::CNTO_W-1:0];
			overflow_q  <= ovf_q || cnt_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign cur_year  = cur_year_q;
	assign cur_month = cur_month_q;
	assign cur_day   = cur_day_q;
	assign date_ok   = date_ok_q;
	assign leap      = leap_out_q;
	assign day_count = day_count_q;
	assign overflow  = overflow_q;

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, cnt_q <= gda_pkg::CNT_W'(gda_pkg::MAX_SPAN))
	`ASSERT_IMPLIES(a_result_from_stored, clk, arst_n, out_load, (wy_q == year_q) && (wm_q == month_q))
	`ASSERT_NEXT(a_result_shown, clk, arst_n, out_load, out_valid)

endmodule

/* tb/sv/gregorian_date_arithmetic_tb.sv */
// Self-checking testbench for the Gregorian date arithmetic block: directed calendar corners,
// a held-output burst, then random traffic. A bench predictor sets each expected result.
// Depends on gda_pkg and on the gregorian_date_arithmetic top level.
module gregorian_date_arithmetic_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gda_pkg::*;

	localparam int unsigned YEAR_MAX    = (1 << YEAR_W) - 1;
	localparam int unsigned COUNT_MAX   = (1 << CNTO_W) - 1;
	localparam int          HOLD_CYCLES = 300;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic              ok;
		logic              lp;
		logic [CNTO_W-1:0] count;
		logic              ovf;
	} date_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [FUNC_W-1:0]   func;
	logic [AMT_W-1:0]    amount;
	logic [YEAR_W-1:0]   arg_year;
	logic [MON_W-1:0]    arg_month;
	logic [DAY_W-1:0]    arg_day;
	logic                out_valid;
	logic                out_ready;
	logic [YEAR_W-1:0]   cur_year;
	logic [MON_W-1:0]    cur_month;
	logic [DAY_W-1:0]    cur_day;
	logic                date_ok;
	logic                leap;
	logic [CNTO_W-1:0]   day_count;
	logic                overflow;

	logic [YEAR_W-1:0]   st_year = '0;
	logic [MON_W-1:0]    st_month = MON_W'(1);
	logic [DAY_W-1:0]    st_day = DAY_W'(1);

	date_result_t        expected_dates[$];
	int                  errors = 0;
	int                  items_sent = 0;
	int                  results_checked = 0;
	int                  op_seen[1 << FUNC_W];
	int                  spare_items = 0;
	int                  span_limit_hits = 0;
	int                  burst_left = 0;
	bit                  tx_steady = 1'b0;
	bit                  hold_results = 1'b0;

	gregorian_date_arithmetic u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.amount    (amount),
		.arg_year  (arg_year),
		.arg_month (arg_month),
		.arg_day   (arg_day),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cur_year  (cur_year),
		.cur_month (cur_month),
		.cur_day   (cur_day),
		.date_ok   (date_ok),
		.leap      (leap),
		.day_count (day_count),
		.overflow  (overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input bit lp);
		int unsigned len;
		case (m)
			1, 3, 5, 7, 8, 10, 12: len = 31;
			4, 6, 9, 11:           len = 30;
			2:                     len = lp ? 29 : 28;
			default:               len = 0;
		endcase
		return len;
	endfunction

	function automatic bit date_valid(input int unsigned y, input int unsigned m,
			input int unsigned d);
		return m >= 1 && m <= 12 && d >= 1 && d <= month_days(m, leap_year(y));
	endfunction

	// Returns 1 when the year wrapped past its 16-bit range.
	function automatic bit roll_days(inout int unsigned y, inout int unsigned m,
			inout int unsigned d, input int unsigned n);
		int unsigned acc;
		bit          wrapped;
		bit          lp;
		acc = d + n;
		wrapped = 1'b0;
		lp = leap_year(y);
		while (acc > month_days(m, lp)) begin
			acc -= month_days(m, lp);
			m++;
			if (m > 12) begin
				m = 1;
				y++;
				if (y > YEAR_MAX) begin
					y = 0;
					wrapped = 1'b1;
				end
				lp = leap_year(y);
			end
		end
		d = acc;
		return wrapped;
	endfunction

	function automatic void count_span(input int unsigned y0, input int unsigned m0,
			input int unsigned d0, output int unsigned n, output bit hit_limit);
		int unsigned ty;
		int unsigned tm;
		int unsigned td;
		bit          wrapped;
		ty = y0;
		tm = m0;
		td = d0;
		n = 0;
		hit_limit = 1'b0;
		while (!(ty == st_year && tm == st_month && td == st_day)) begin
			if (n >= MAX_SPAN) begin
				hit_limit = 1'b1;
				break;
			end
			wrapped = roll_days(ty, tm, td, 1);
			n++;
		end
		if (n > COUNT_MAX) begin
			n = COUNT_MAX;
			hit_limit = 1'b1;
		end
	endfunction

	function automatic date_result_t calendar_step(input logic [FUNC_W-1:0] f,
			input logic [AMT_W-1:0] amt, input logic [YEAR_W-1:0] ay,
			input logic [MON_W-1:0] am, input logic [DAY_W-1:0] ad);
		date_result_t r;
		int unsigned  y;
		int unsigned  m;
		int unsigned  d;
		int unsigned  k;
		int unsigned  n;
		int unsigned  dom;
		bit           ovf;
		y = st_year;
		m = st_month;
		d = st_day;
		n = 0;
		ovf = 1'b0;
		case (f)
			F_LOAD: begin
				y = ay;
				m = am;
				d = ad;
			end
			F_ADD_DAYS: ovf = roll_days(y, m, d, amt);
			F_ADD_MONTHS: begin
				m = m + amt;
				if (m > 12) begin
					k = (m - 13) / 12 + 1;
					m -= 12 * k;
					y += k;
					if (y > YEAR_MAX) begin
						y &= YEAR_MAX;
						ovf = 1'b1;
					end
				end
				dom = month_days(m, leap_year(y));
				if (d > dom)
					d = dom;
			end
			F_ADD_YEARS: begin
				y += amt;
				if (y > YEAR_MAX) begin
					y &= YEAR_MAX;
					ovf = 1'b1;
				end
			end
			F_DAYS_SINCE: count_span(ay, am, ad, n, ovf);
			default: ;
		endcase
		st_year = y;
		st_month = m;
		st_day = d;
		r.year = y;
		r.month = m;
		r.day = d;
		r.ok = date_valid(y, m, d);
		r.lp = leap_year(y);
		r.count = n;
		r.ovf = ovf;
		return r;
	endfunction

	function automatic void step_back(inout int unsigned y, inout int unsigned m,
			inout int unsigned d);
		if (d > 1) begin
			d--;
		end else begin
			if (m > 1) begin
				m--;
			end else begin
				m = 12;
				y = (y == 0) ? YEAR_MAX : y - 1;
			end
			d = month_days(m, leap_year(y));
		end
	endfunction

	function automatic void pick_valid_date(output logic [YEAR_W-1:0] y,
			output logic [MON_W-1:0] m, output logic [DAY_W-1:0] d);
		int unsigned r;
		int unsigned len;
		r = $urandom_range(0, 99);
		if (r < 40)
			y = $urandom_range(1583, 2500);
		else if (r < 60)
			y = $urandom;
		else if (r < 75)
			y = $urandom_range(YEAR_MAX - 35, YEAR_MAX);
		else if (r < 85)
			y = $urandom_range(0, 10);
		else
			y = $urandom_range(0, YEAR_MAX / 100) * 100;
		m = $urandom_range(1, 12);
		len = month_days(m, leap_year(y));
		d = ($urandom_range(0, 9) < 3) ? len : $urandom_range(1, len);
	endfunction

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [AMT_W-1:0] amt,
			input logic [YEAR_W-1:0] ay, input logic [MON_W-1:0] am,
			input logic [DAY_W-1:0] ad);
		int           gap;
		date_result_t want;
		if (!tx_steady && burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		func <= f;
		amount <= amt;
		arg_year <= ay;
		arg_month <= am;
		arg_day <= ad;
		do @(posedge clk); while (!in_ready);
		want = calendar_step(f, amt, ay, am, ad);
		expected_dates.push_back(want);
		items_sent++;
		if (f > F_DAYS_SINCE)
			spare_items++;
		else
			op_seen[f]++;
		if (f == F_DAYS_SINCE && want.ovf)
			span_limit_hits++;
	endtask

	task automatic load_date(input logic [YEAR_W-1:0] y, input logic [MON_W-1:0] m,
			input logic [DAY_W-1:0] d);
		send_item(F_LOAD, $urandom, y, m, d);
	endtask

	task automatic apply_op(input func_t f, input logic [AMT_W-1:0] amt);
		send_item(f, amt, $urandom, $urandom, $urandom);
	endtask

	task automatic count_from(input logic [YEAR_W-1:0] y, input logic [MON_W-1:0] m,
			input logic [DAY_W-1:0] d);
		send_item(F_DAYS_SINCE, $urandom, y, m, d);
	endtask

	task automatic settle_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_dates.size() != 0);
	endtask

	task automatic send_random_item();
		logic [FUNC_W-1:0] f;
		logic [AMT_W-1:0]  amt;
		logic [YEAR_W-1:0] ay;
		logic [MON_W-1:0]  am;
		logic [DAY_W-1:0]  ad;
		int unsigned       pick;
		int unsigned       r;
		int unsigned       y;
		int unsigned       m;
		int unsigned       d;
		int unsigned       span;
		bit                hit_limit;
		bit                found;
		amt = $urandom;
		ay = $urandom;
		am = $urandom;
		ad = $urandom;
		r = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			f = F_LOAD;
			pick_valid_date(ay, am, ad);
		end else if (pick < 15) begin
			f = F_LOAD;
		end else if (pick < 40) begin
			f = F_ADD_DAYS;
			if (r >= 1)
				amt = (r < 40) ? $urandom_range(0, 40) : $urandom_range(0, 400);
		end else if (pick < 55) begin
			f = F_ADD_MONTHS;
			if (r >= 6)
				amt = $urandom_range(0, 40);
		end else if (pick < 67) begin
			f = F_ADD_YEARS;
			if (r >= 6)
				amt = $urandom_range(0, 400);
		end else if (pick < 97) begin
			f = F_DAYS_SINCE;
			y = st_year;
			m = st_month;
			d = st_day;
			found = !date_valid(y, m, d);
			if (!found && r < 15) begin
				m = $urandom_range(0, (1 << MON_W) - 1);
				d = $urandom_range(0, (1 << DAY_W) - 1);
				count_span(y, m, d, span, hit_limit);
				found = !hit_limit && span <= 1000;
				if (!found) begin
					m = st_month;
					d = st_day;
				end
			end
			if (!found) begin
				span = (r < 70) ? $urandom_range(0, 40) :
					(r < 97) ? $urandom_range(0, 400) : $urandom_range(0, 1000);
				repeat (span) step_back(y, m, d);
			end
			ay = y;
			am = m;
			ad = d;
		end else begin
			f = $urandom_range(F_DAYS_SINCE + 1, (1 << FUNC_W) - 1);
		end
		send_item(f, amt, ay, am, ad);
	endtask

	task automatic test_loads_and_spare_codes();
		load_date(YEAR_MAX, (1 << MON_W) - 1, (1 << DAY_W) - 1);
		apply_op(F_ADD_DAYS, 0);
		load_date(0, 0, 0);
		apply_op(F_ADD_DAYS, 5);
		for (int f = F_DAYS_SINCE + 1; f < (1 << FUNC_W); f++)
			send_item(f, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_day_rollover();
		load_date(2023, 3, 0);
		apply_op(F_ADD_DAYS, 0);
		load_date(2023, 12, 31);
		apply_op(F_ADD_DAYS, 1);
		apply_op(F_ADD_DAYS, 59);
		load_date(1900, 2, 28);
		apply_op(F_ADD_DAYS, 1);
	endtask

	task automatic test_month_and_year_steps();
		apply_op(F_ADD_YEARS, AMT_W'(YEAR_MAX));
		load_date(2000, 1, 31);
		apply_op(F_ADD_MONTHS, 1);
		apply_op(F_ADD_YEARS, 1);
		apply_op(F_ADD_MONTHS, 12);
		apply_op(F_ADD_MONTHS, AMT_W'(YEAR_MAX));
		load_date(YEAR_MAX, 12, 31);
		apply_op(F_ADD_MONTHS, 1);
	endtask

	task automatic test_day_counting();
		load_date(2024, 3, 1);
		count_from(2024, 2, 28);
		count_from(2024, 3, 1);
		// A start after the stored date never meets it and runs to the span limit.
		count_from(2024, 3, 2);
		load_date(0, 1, 1);
		count_from(YEAR_MAX, 12, 31);
		// February 30 is never reached by stepping forward.
		load_date(2023, 2, 30);
		count_from(2023, 2, 1);
	endtask

	task automatic test_output_backpressure();
		hold_results = 1'b1;
		tx_steady = 1'b1;
		repeat (8) send_random_item();
		tx_steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 7; phase++) begin
			repeat (245) send_random_item();
			settle_results();
		end
	endtask

	initial begin
		int win_left;
		int duty;
		out_ready = 1'b0;
		win_left = 0;
		duty = 100;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_results) begin
				out_ready <= 1'b0;
				for (int held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_results = 1'b0;
			end else begin
				if (win_left == 0) begin
					win_left = $urandom_range(16, 96);
					case ($urandom_range(0, 3))
						0:       duty = 100;
						1:       duty = 75;
						2:       duty = 40;
						default: duty = 10;
					endcase
				end
				win_left--;
				out_ready <= ($urandom_range(1, 100) <= duty);
			end
		end
	end

	always @(posedge clk) begin : check_results
		date_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_dates.size() == 0) begin
				$error("result arrived with no item outstanding");
				errors++;
			end else begin
				want = expected_dates.pop_front();
				results_checked++;
				if (cur_year !== want.year) begin
					$error("cur_year: expected %0d, got %0d", want.year, cur_year);
					errors++;
				end
				if (cur_month !== want.month) begin
					$error("cur_month: expected %0d, got %0d", want.month, cur_month);
					errors++;
				end
				if (cur_day !== want.day) begin
					$error("cur_day: expected %0d, got %0d", want.day, cur_day);
					errors++;
				end
				if (date_ok !== want.ok) begin
					$error("date_ok: expected %0d, got %0d", want.ok, date_ok);
					errors++;
				end
				if (leap !== want.lp) begin
					$error("leap: expected %0d, got %0d", want.lp, leap);
					errors++;
				end
				if (day_count !== want.count) begin
					$error("day_count: expected %0d, got %0d", want.count, day_count);
					errors++;
				end
				if (overflow !== want.ovf) begin
					$error("overflow: expected %0d, got %0d", want.ovf, overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = F_LOAD;
		amount = '0;
		arg_year = '0;
		arg_month = '0;
		arg_day = '0;
		foreach (op_seen[i])
			op_seen[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_loads_and_spare_codes();
		test_day_rollover();
		test_month_and_year_steps();
		test_day_counting();
		settle_results();
		test_output_backpressure();
		settle_results();
		test_random_traffic();
		settle_results();
		repeat (64) @(posedge clk);
		if (expected_dates.size() != 0) begin
			$error("%0d results never arrived", expected_dates.size());
			errors++;
		end
		$display("Sent %0d items, checked %0d results: %0d loads, %0d day adds, %0d month adds,",
			items_sent, results_checked, op_seen[F_LOAD], op_seen[F_ADD_DAYS],
			op_seen[F_ADD_MONTHS]);
		$display("%0d year adds, %0d day counts (%0d at the span limit), %0d spare codes.",
			op_seen[F_ADD_YEARS], op_seen[F_DAYS_SINCE], span_limit_hits, spare_items);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/gda_pkg.sv
hdl/gregorian_date_arithmetic.sv
tb/sv/gregorian_date_arithmetic_tb.sv
